// ===== src/anbs_pkg.sv =====
// Package: shared types and constants for the Annex-B NAL boundary scanner.
`timescale 1ns / 1ps

package anbs_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int FIELD_BITS      = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] CODE_SIZE_SHORT = 3'd3;
  localparam logic [2:0] CODE_SIZE_LONG  = 3'd4;
  localparam logic [1:0] ZERO_RUN_MAX    = 2'd3;
  localparam logic [7:0] BYTE_ZERO       = 8'h00;
  localparam logic [7:0] BYTE_ONE        = 8'h01;

  typedef enum logic [1:0] {
    KIND_NAL        = 2'd0,
    KIND_NO_CODE    = 2'd1,
    KIND_EARLY_DATA = 2'd2,
    KIND_EMPTY_NAL  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    kind_e                   result_kind;
    logic [FIELD_BITS-1:0]   unit_number;
    logic [FIELD_BITS-1:0]   start_offset;
    logic [2:0]              start_size;
    logic [FIELD_BITS-1:0]   body_offset;
    logic [FIELD_BITS-1:0]   body_size;
    logic [FIELD_BITS-1:0]   fault_offset;
    logic                    final_result;
  } out_word_t;

  // Results produced by one byte: count (0..2) and the words in order.
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  word0;
    out_word_t  word1;
  } push_t;

endpackage

// ===== src/anbs_stream_if.sv =====
// Interface: valid/ready stream channel carrying one word per handshake.
`timescale 1ns / 1ps

interface anbs_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/anbs_scanner.sv =====
// Scanner: input stage register, zero-run tracking and NAL unit bookkeeping.
`timescale 1ns / 1ps

module anbs_scanner import anbs_pkg::*; #(
  parameter int OffsetBits = OFFSET_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_word_t word_i,
  output push_t    push_o
);

  localparam logic [OffsetBits-1:0] OffMax = {OffsetBits{1'b1}};

  // Saturating add of a small amount.
  function automatic logic [OffsetBits-1:0] sat_add(input logic [OffsetBits-1:0] a,
                                                    input logic [2:0] b);
    logic [OffsetBits:0] s;
    s = {1'b0, a} + (OffsetBits+1)'(b);
    return s[OffsetBits] ? OffMax : s[OffsetBits-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] clip(input logic [OffsetBits-1:0] v);
    logic [63:0] x;
    x = 64'(v);
    return (|x[63:32]) ? {FIELD_BITS{1'b1}} : x[31:0];
  endfunction

  function automatic out_word_t err_word(input kind_e kind,
                                         input logic [OffsetBits-1:0] unit,
                                         input logic [OffsetBits-1:0] fault);
    out_word_t w;
    w = '0;
    w.result_kind  = kind;
    w.unit_number  = clip(unit);
    w.fault_offset = clip(fault);
    w.final_result = 1'b1;
    return w;
  endfunction

  // Close the open unit: a unit word, or an empty-unit error without payload.
  function automatic out_word_t close_word(input logic [OffsetBits-1:0] off,
                                           input logic [2:0]            csize,
                                           input logic                  has,
                                           input logic [OffsetBits-1:0] mark,
                                           input logic [OffsetBits-1:0] units,
                                           input logic                  fin);
    out_word_t           w;
    logic [OffsetBits-1:0] body;
    logic [OffsetBits-1:0] len;
    body = sat_add(off, csize);
    len  = (mark > body) ? mark - body : '0;
    if (!has) begin
      w = err_word(KIND_EMPTY_NAL, units, body);
    end else begin
      w = '0;
      w.result_kind  = KIND_NAL;
      w.unit_number  = clip(units);
      w.start_offset = clip(off);
      w.start_size   = csize;
      w.body_offset  = clip(body);
      w.body_size    = clip(len);
      w.final_result = fin;
    end
    return w;
  endfunction

  // Input stage
  logic     stg_valid_q;
  in_word_t stg_word_q;

  // Scan state
  logic [OffsetBits-1:0] pos_q, pos_d;
  logic [1:0]            zrun_q, zrun_d;
  logic                  seen_q, seen_d;
  logic                  ebv_q, ebv_d;
  logic [OffsetBits-1:0] ebp_q, ebp_d;
  logic [OffsetBits-1:0] cur_off_q, cur_off_d;
  logic [2:0]            cur_size_q, cur_size_d;
  logic [OffsetBits-1:0] mark_q, mark_d;
  logic                  has_q, has_d;
  logic [OffsetBits-1:0] units_q, units_d;
  logic                  halt_q, halt_d;

  logic                  is_zero, is_code;
  logic [2:0]            code_size;
  logic [OffsetBits-1:0] code_back;
  logic [OffsetBits-1:0] code_off;
  logic [1:0]            n_res;
  out_word_t             w0, w1, fin_word;

  assign is_zero   = (stg_word_q.data_byte == BYTE_ZERO);
  assign is_code   = (stg_word_q.data_byte == BYTE_ONE) && zrun_q[1];
  assign code_size = (zrun_q == ZERO_RUN_MAX) ? CODE_SIZE_LONG : CODE_SIZE_SHORT;
  assign code_back = OffsetBits'(code_size - 3'd1);
  assign code_off  = (pos_q >= code_back) ? pos_q - code_back : '0;

  always_comb begin
    pos_d      = sat_add(pos_q, 3'd1);
    zrun_d     = zrun_q;
    seen_d     = seen_q;
    ebv_d      = ebv_q;
    ebp_d      = ebp_q;
    cur_off_d  = cur_off_q;
    cur_size_d = cur_size_q;
    mark_d     = mark_q;
    has_d      = has_q;
    units_d    = units_q;
    halt_d     = halt_q;
    n_res      = 2'd0;
    w0         = '0;
    w1         = '0;
    fin_word   = '0;

    if (!halt_q) begin
      if (is_code) begin
        if (!seen_q) begin
          if (ebv_q) begin
            w0     = err_word(KIND_EARLY_DATA, '0, ebp_q);
            n_res  = 2'd1;
            halt_d = 1'b1;
          end else begin
            seen_d = 1'b1;
          end
        end else begin
          w0    = close_word(cur_off_q, cur_size_q, has_q, mark_q, units_q, 1'b0);
          n_res = 2'd1;
          if (!has_q) begin
            halt_d = 1'b1;
          end else if (units_q != OffMax) begin
            units_d = units_q + OffsetBits'(1);
          end
        end
        if (!halt_d) begin
          cur_off_d  = code_off;
          cur_size_d = code_size;
          has_d      = 1'b0;
          mark_d     = '0;
        end
      end else if (!is_zero) begin
        if (!seen_q) begin
          if (!ebv_q) begin
            ebv_d = 1'b1;
            ebp_d = pos_q;
          end
        end else begin
          has_d  = 1'b1;
          mark_d = sat_add(pos_q, 3'd1);
        end
      end
      if (is_zero) begin
        zrun_d = (zrun_q == ZERO_RUN_MAX) ? ZERO_RUN_MAX : zrun_q + 2'd1;
      end else begin
        zrun_d = 2'd0;
      end
    end

    if (stg_word_q.end_of_stream) begin
      if (!halt_d) begin
        if (!seen_d) begin
          fin_word = err_word(KIND_NO_CODE, '0, '0);
        end else begin
          fin_word = close_word(cur_off_d, cur_size_d, has_d, mark_d, units_d, 1'b1);
        end
        if (n_res == 2'd0) begin
          w0 = fin_word;
        end else begin
          w1 = fin_word;
        end
        n_res = n_res + 2'd1;
      end
      // Stream done: back to the reset state.
      pos_d      = '0;
      zrun_d     = 2'd0;
      seen_d     = 1'b0;
      ebv_d      = 1'b0;
      ebp_d      = '0;
      cur_off_d  = '0;
      cur_size_d = CODE_SIZE_SHORT;
      mark_d     = '0;
      has_d      = 1'b0;
      units_d    = '0;
      halt_d     = 1'b0;
    end
  end

  always_comb begin
    push_o.cnt   = stg_valid_q ? n_res : 2'd0;
    push_o.word0 = w0;
    push_o.word1 = w1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stg_word_q <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      zrun_q     <= 2'd0;
      seen_q     <= 1'b0;
      ebv_q      <= 1'b0;
      ebp_q      <= '0;
      cur_off_q  <= '0;
      cur_size_q <= CODE_SIZE_SHORT;
      mark_q     <= '0;
      has_q      <= 1'b0;
      units_q    <= '0;
      halt_q     <= 1'b0;
    end else if (stg_valid_q) begin
      pos_q      <= pos_d;
      zrun_q     <= zrun_d;
      seen_q     <= seen_d;
      ebv_q      <= ebv_d;
      ebp_q      <= ebp_d;
      cur_off_q  <= cur_off_d;
      cur_size_q <= cur_size_d;
      mark_q     <= mark_d;
      has_q      <= has_d;
      units_q    <= units_d;
      halt_q     <= halt_d;
    end
  end

endmodule

// ===== src/anbs_result_queue.sv =====
// Result queue: small shift queue taking up to two words and giving one per cycle while popped.
`timescale 1ns / 1ps

module anbs_result_queue import anbs_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  push_t                     push_i,
  input  logic                      pop_i,
  output out_word_t                 head_o,
  output logic [QUEUE_CNT_BITS-1:0] count_o
);

  out_word_t                 ent_q [QUEUE_DEPTH];
  out_word_t                 ent_d [QUEUE_DEPTH];
  logic [QUEUE_CNT_BITS-1:0] cnt_q, cnt_d, cnt_mid;

  always_comb begin
    ent_d   = ent_q;
    cnt_mid = cnt_q;
    if (pop_i) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
      cnt_mid = cnt_q - QUEUE_CNT_BITS'(1);
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (push_i.cnt != 2'd0 && QUEUE_CNT_BITS'(i) == cnt_mid) begin
        ent_d[i] = push_i.word0;
      end
      if (push_i.cnt == 2'd2 && QUEUE_CNT_BITS'(i) == cnt_mid + QUEUE_CNT_BITS'(1)) begin
        ent_d[i] = push_i.word1;
      end
    end
    cnt_d = cnt_mid + QUEUE_CNT_BITS'(push_i.cnt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign head_o  = ent_q[0];
  assign count_o = cnt_q;

endmodule

// ===== src/annex_b_nal_boundary_scanner.sv =====
// Top level: Annex-B NAL unit boundary scanner, byte stream in, unit records out.
//
//   channel | dir | word        | fields
//   --------+-----+-------------+------------------------------------------------
//   in_i    | in  | in_word_t   | data_byte, end_of_stream
//   out_o   | out | out_word_t  | result_kind, unit_number, start_offset,
//           |     |             | start_size, body_offset, body_size,
//           |     |             | fault_offset, final_result
//
// One byte per cycle sustained. A byte is registered at acceptance, scanned in
// the next cycle and its words (0, 1 or 2) land in a 4-word result queue, so the
// first word passes the stage register and then the queue before it can leave.
// Input ready comes from registers only: queue fill plus the words of the byte
// in the stage must leave room for two more. A stalled output fills the queue
// and then holds off input; a byte that makes two words costs one extra output
// handshake. Reset is asynchronous and clears the scan state, stage and queue.
`timescale 1ns / 1ps

module annex_b_nal_boundary_scanner import anbs_pkg::*; #(
  parameter int OffsetBits = OFFSET_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  anbs_stream_if.sink   in_i,
  anbs_stream_if.source out_o
);

  push_t                     push;
  logic                      accept;
  logic                      pop;
  logic [QUEUE_CNT_BITS-1:0] q_count;
  logic [QUEUE_CNT_BITS-1:0] committed;

  // Words already queued plus words about to be pushed by the staged byte.
  assign committed = q_count + QUEUE_CNT_BITS'(push.cnt);
  assign in_i.ready = (committed <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
  assign accept     = in_i.valid && in_i.ready;

  anbs_scanner #(
    .OffsetBits(OffsetBits)
  ) u_scanner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .word_i  (in_i.payload),
    .push_o  (push)
  );

  assign out_o.valid = (q_count != '0);
  assign pop         = out_o.valid && out_o.ready;

  anbs_result_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (out_o.payload),
    .count_o(q_count)
  );

endmodule
